@@ design/ajrb_pkg.sv @@
package ajrb_pkg;

   localparam int DEPTH    = 4096;
   localparam int CHANNELS = 2;
   localparam int PTR_W    = $clog2(DEPTH);

   localparam int SAMPLE_W = 16;
   localparam int MIX_W    = 24;
   localparam int GAIN_W   = 16;
   localparam int FILL_W   = 12;
   localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
   localparam int SCALE_W  = PROD_W - 15;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 64;

   typedef logic [PTR_W-1:0] ptr_type;

   // Item kinds, carried on req_tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_STREAM_ENABLE = 2'd0,
      CSR_GAIN          = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MIX
   } state_type;

endpackage

@@ design/ajrb_ram.sv @@
module ajrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/ajrb_mixer.sv @@
module ajrb_mixer
   import ajrb_pkg::*;
(
   input  logic                       clock,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic        [GAIN_W-1:0]   gain,
   input  logic signed [MIX_W-1:0]    mix,
   output logic signed [MIX_W-1:0]    mixed
);

   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [SCALE_W-1:0] scaled;
   logic signed [MIX_W:0]     sum;

   // The gain is unsigned, so it enters the multiply with a zero sign bit.
   assign prod_in = sample * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Dropping the low 15 bits of a two's complement product rounds toward minus infinity.
   assign scaled = prod_ff[PROD_W-1:15];
   assign sum    = MIX_W'(0) + {mix[MIX_W-1], mix} + (MIX_W+1)'(scaled);

   always_comb begin
      case (sum[MIX_W:MIX_W-1])
         2'b01:   mixed = {1'b0, {(MIX_W-1){1'b1}}};
         2'b10:   mixed = {1'b1, {(MIX_W-1){1'b0}}};
         default: mixed = sum[MIX_W-1:0];
      endcase
   end

endmodule

@@ design/audio_jitter_ring_buffer_top.sv @@
// Stereo audio jitter buffer on a circular frame store.
// Items enter on the req_ channel. req_tuser selects a write (store one PCM frame at the
// write pointer) or a read (consume one frame at the read pointer and mix it, scaled by
// the gain, into the supplied mix values with 24-bit saturation). Every item returns one
// item on the rsp_ channel with the outputs, a frame-read flag and the fill level.
// Writes never check for overflow; an overrun wraps the fill level toward zero.
// A read consumes a frame only when streaming is enabled and the buffer is not empty.
// Registers are written over the csr_ channel, which is always ready; write them only
// while no item is in flight.
// A write or a read that consumes nothing answers in the cycle after acceptance; a read
// that consumes a frame answers after the synchronous frame store read, the registered
// gain multiply and the add and saturate. Writes and empty reads are taken at one item
// per cycle while the receiver does not stall; a consuming read holds req_tready low
// until its result is registered.
// The result sits in an output register; while the receiver stalls, that register holds
// and req_tready stays low. A new item is taken in the same cycle the result is taken.
// Reset clears the pointers, the state machine and the output valid, and restores the
// register defaults. The frame store is not cleared.
module audio_jitter_ring_buffer_top
   import ajrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // sample_left[15:0], sample_right[31:16], mix_left[55:32], mix_right[79:56]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[0]
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // out_left[23:0], out_right[47:24], fill_level[59:48], zero[63:60]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // frame_read[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_addr,
   input  logic [GAIN_W-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   logic              enable_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [1:0]        chan_ff;

   ptr_type wr_ptr_ff, wr_ptr_in;
   ptr_type rd_ptr_ff, rd_ptr_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [MIX_W-1:0] out_left_ff, out_left_in;
   logic signed [MIX_W-1:0] out_right_ff, out_right_in;
   logic                    frame_read_ff, frame_read_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;

   logic signed [MIX_W-1:0] mix_left_ff, mix_left_in;
   logic signed [MIX_W-1:0] mix_right_ff, mix_right_in;
   logic                    mono_ff, mono_in;

   logic                       accept;
   logic                       mono;
   logic                       ram_we_left;
   logic                       ram_we_right;
   logic signed [SAMPLE_W-1:0] sample_left;
   logic signed [SAMPLE_W-1:0] sample_right;
   logic signed [MIX_W-1:0]    mix_left;
   logic signed [MIX_W-1:0]    mix_right;
   logic [SAMPLE_W-1:0]        frame_left;
   logic [SAMPLE_W-1:0]        frame_right;
   logic signed [MIX_W-1:0]    mixed_left;
   logic signed [MIX_W-1:0]    mixed_right;

   assign sample_left  = req_tdata[15:0];
   assign sample_right = req_tdata[31:16];
   assign mix_left     = req_tdata[55:32];
   assign mix_right    = req_tdata[79:56];

   assign mono       = (chan_ff == 2'd1) || (CHANNELS == 1);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ram_we_left  = accept && (req_tuser == OP_WRITE);
   assign ram_we_right = ram_we_left && !mono;

   // Left and right halves live in separate stores so a mono write leaves the right half.
   ajrb_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_left (
      .clock   (clock),
      .wr_en   (ram_we_left),
      .wr_addr (wr_ptr_ff),
      .wr_data (sample_left),
      .rd_addr (rd_ptr_ff),
      .rd_data (frame_left)
   );

   ajrb_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram_right (
      .clock   (clock),
      .wr_en   (ram_we_right),
      .wr_addr (wr_ptr_ff),
      .wr_data (sample_right),
      .rd_addr (rd_ptr_ff),
      .rd_data (frame_right)
   );

   ajrb_mixer u_mix_left (
      .clock  (clock),
      .sample (frame_left),
      .gain   (gain_ff),
      .mix    (mix_left_ff),
      .mixed  (mixed_left)
   );

   ajrb_mixer u_mix_right (
      .clock  (clock),
      .sample (frame_right),
      .gain   (gain_ff),
      .mix    (mix_right_ff),
      .mixed  (mixed_right)
   );

   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_left_in   = out_left_ff;
      out_right_in  = out_right_ff;
      frame_read_in = frame_read_ff;
      fill_in       = fill_ff;
      mix_left_in   = mix_left_ff;
      mix_right_in  = mix_right_ff;
      mono_in       = mono_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_WRITE) begin
                  wr_ptr_in     = wr_ptr_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  out_left_in   = '0;
                  out_right_in  = '0;
                  frame_read_in = 1'b0;
                  fill_in       = FILL_W'(ptr_type'(wr_ptr_ff + 1'b1 - rd_ptr_ff));
               end else if (enable_ff && (wr_ptr_ff != rd_ptr_ff)) begin
                  // The frame at the read pointer is already being fetched.
                  rd_ptr_in    = rd_ptr_ff + 1'b1;
                  fill_in      = FILL_W'(ptr_type'(wr_ptr_ff - rd_ptr_ff - 1'b1));
                  mix_left_in  = mix_left;
                  mix_right_in = mix_right;
                  mono_in      = mono;
                  state_in     = ST_FETCH;
               end else begin
                  rsp_valid_in  = 1'b1;
                  out_left_in   = mix_left;
                  out_right_in  = mix_right;
                  frame_read_in = 1'b0;
                  fill_in       = FILL_W'(ptr_type'(wr_ptr_ff - rd_ptr_ff));
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            rsp_valid_in  = 1'b1;
            out_left_in   = mixed_left;
            out_right_in  = mono_ff ? mix_right_ff : mixed_right;
            frame_read_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         gain_ff      <= GAIN_W'(32768);
         chan_ff      <= 2'd2;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_STREAM_ENABLE: enable_ff <= csr_wdata[0];
               CSR_GAIN:          gain_ff   <= csr_wdata;
               CSR_CHANNEL_COUNT: chan_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_left_ff   <= out_left_in;
      out_right_ff  <= out_right_in;
      frame_read_ff <= frame_read_in;
      fill_ff       <= fill_in;
      mix_left_ff   <= mix_left_in;
      mix_right_ff  <= mix_right_in;
      mono_ff       <= mono_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = frame_read_ff;
   assign rsp_tdata  = {4'b0, fill_ff, out_right_ff, out_left_ff};

endmodule

@@ design/ajrb_checker.sv @@
module ajrb_checker
   import ajrb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tuser,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // A stalled result must hold its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // A write answers in the next cycle and never reports a consumed frame.
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_WRITE) |=> rsp_tvalid && !rsp_tuser)
      else $error("write item result missing or flagged as read");

   // No new item is taken while a result waits on a stalled receiver.
   a_no_overtake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted while result stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind audio_jitter_ring_buffer_top ajrb_checker u_ajrb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
